// ===== src/ecac_pkg.sv =====
// ============================================================================
// ecac_pkg
// Shared types and codes for the cellular automaton cascade classifier.
// ============================================================================
package ecac_pkg;

    // Width of the ring fields on the ports and of the rule byte register.
    localparam int FIELD_W   = 64;
    localparam int RULE_W    = 8;
    localparam int TOTAL_W   = 4;
    localparam int MODE_W    = 2;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_RULE_BYTES    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_RULE_TOTAL    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CLASSIFY_MODE = 2'd2;

    // Reduction modes; the unused code falls back to majority.
    localparam logic [MODE_W-1:0] MODE_MAJORITY = 2'd0;
    localparam logic [MODE_W-1:0] MODE_XOR      = 2'd1;
    localparam logic [MODE_W-1:0] MODE_BIT_ZERO = 2'd2;

    // Control bundle handed to every generation stage.
    typedef struct packed {
        logic              en;     // pipeline advance
        logic              apply;  // this stage's rule is part of the cascade
        logic [RULE_W-1:0] rule;   // Wolfram rule number
    } t_stage_ctl;

endpackage

// ===== src/ecac_gen_stage.sv =====
// ============================================================================
// ecac_gen_stage
// One registered generation of an elementary cellular automaton on a ring.
// ============================================================================
module ecac_gen_stage
    import ecac_pkg::*;
#(
    parameter int CELLS = 64
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_stage_ctl       i_ctl,
    input  logic             i_valid,
    input  logic [CELLS-1:0] i_ring,
    output logic             o_valid,
    output logic [CELLS-1:0] o_ring
);

    logic             r_valid;
    logic [CELLS-1:0] r_ring;
    logic [CELLS-1:0] n_ring;
    logic [CELLS-1:0] gen_ring;

    // Each new cell looks up the rule at {left, self, right}.
    for (genvar j = 0; j < CELLS; j++) begin : g_cell
        localparam int LPOS = (j == 0) ? CELLS - 1 : j - 1;
        localparam int RPOS = (j == CELLS - 1) ? 0 : j + 1;
        assign gen_ring[j] = i_ctl.rule[{i_ring[LPOS], i_ring[j], i_ring[RPOS]}];
    end

    assign n_ring = i_ctl.apply ? gen_ring : i_ring;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            r_ring <= n_ring;
        end
    end

    assign o_valid = r_valid;
    assign o_ring  = r_ring;

endmodule

// ===== src/ecac_reduce.sv =====
// ============================================================================
// ecac_reduce
// Two-stage reduction of the final ring to one class bit.
// ============================================================================
module ecac_reduce
    import ecac_pkg::*;
#(
    parameter int CELLS = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [MODE_W-1:0] i_mode,
    input  logic              i_valid,
    input  logic [CELLS-1:0]  i_ring,
    output logic              o_valid,
    output logic              o_class,
    output logic [CELLS-1:0]  o_ring
);

    localparam int NG   = (CELLS + 7) / 8;
    localparam int GW   = 4;
    localparam int CW   = $clog2(CELLS + 1);
    localparam int HALF = CELLS / 2;

    logic [NG*8-1:0]     pad_ring;
    logic [GW-1:0]       n_grp [NG];
    logic [GW-1:0]       r_grp [NG];
    logic                r_v1;
    logic [CELLS-1:0]    r_ring1;
    logic                r_xor1;
    logic                r_bit1;
    logic [MODE_W-1:0]   r_mode1;
    logic [CW-1:0]       ones;
    logic                n_class;
    logic                r_v2;
    logic                r_class2;
    logic [CELLS-1:0]    r_ring2;

    assign pad_ring = (NG*8)'(i_ring);

    // First stage: population count of each byte of the ring.
    always_comb begin
        for (int g = 0; g < NG; g++) begin
            n_grp[g] = '0;
            for (int b = 0; b < 8; b++) begin
                n_grp[g] = n_grp[g] + GW'(pad_ring[g*8 + b]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else if (i_en) begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_grp    <= n_grp;
            r_ring1  <= i_ring;
            r_xor1   <= ^i_ring;
            r_bit1   <= i_ring[0];
            r_mode1  <= i_mode;
            r_class2 <= n_class;
            r_ring2  <= r_ring1;
        end
    end

    // Second stage: total the byte counts and pick the class bit.
    always_comb begin
        ones = '0;
        for (int g = 0; g < NG; g++) begin
            ones = ones + CW'(r_grp[g]);
        end
        case (r_mode1)
            MODE_XOR:      n_class = r_xor1;
            MODE_BIT_ZERO: n_class = r_bit1;
            default:       n_class = (ones > CW'(HALF));
        endcase
    end

    assign o_valid = r_v2;
    assign o_class = r_class2;
    assign o_ring  = r_ring2;

endmodule

// ===== src/cellular_automaton_cascade_classifier_top.sv =====
// ============================================================================
// cellular_automaton_cascade_classifier_top
// Elementary cellular automaton cascade with a one-bit ring classifier.
// ============================================================================
// Each input beat carries a ring of CELLS bits (bits of i_start_cells at
// CELLS and above are ignored). The ring passes through a cascade of up to
// MAX_RULES elementary cellular automaton rules, each run for CELLS-1
// generations with wraparound neighbours; the new cell is the rule bit at
// 4*left + 2*self + right. The final ring is reduced to a class bit by
// majority (a tie gives 0), by the XOR of all cells, or by cell 0, and both
// the class bit and the final ring are returned as one output beat.
// The block accepts one beat per clock cycle while the skid register is
// empty. Every generation is one pipeline stage, so MAX_RULES*(CELLS-1)
// generation stages are always present; stages whose rule lies beyond
// rule_total pass the ring unchanged. Two reduction stages and the output
// register follow. A stall on the output is absorbed by a skid register,
// and the pipeline advances as a whole whenever that skid register is
// empty. Configuration is written through a plain write port and must
// only be changed while no beat is in flight.
// ============================================================================
module cellular_automaton_cascade_classifier_top
    import ecac_pkg::*;
#(
    parameter int CELLS     = 64,
    parameter int MAX_RULES = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [FIELD_W-1:0]   i_cfg_data,
    // Input channel.
    input  logic                 i_in_valid,
    output logic                 o_in_ready,
    input  logic [FIELD_W-1:0]   i_start_cells,
    // Output channel.
    output logic                 o_out_valid,
    input  logic                 i_out_ready,
    output logic                 o_class_bit,
    output logic [FIELD_W-1:0]   o_final_cells
);

    localparam int GENS    = CELLS - 1;
    localparam int NSTAGES = MAX_RULES * GENS;

    // Configuration registers.
    logic [FIELD_W-1:0] r_rule_bytes;
    logic [TOTAL_W-1:0] r_rule_total;
    logic [MODE_W-1:0]  r_mode;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rule_bytes <= '0;
            r_rule_total <= TOTAL_W'(1);
            r_mode       <= MODE_MAJORITY;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_RULE_BYTES:    r_rule_bytes <= i_cfg_data;
                REG_RULE_TOTAL:    r_rule_total <= i_cfg_data[TOTAL_W-1:0];
                REG_CLASSIFY_MODE: r_mode       <= i_cfg_data[MODE_W-1:0];
                default:           ;
            endcase
        end
    end

    // Rule count, clamped to the number of rule slots built.
    logic [TOTAL_W-1:0] active_rules;
    assign active_rules = (r_rule_total > TOTAL_W'(MAX_RULES))
                        ? TOTAL_W'(MAX_RULES) : r_rule_total;

    // The whole pipeline moves while the skid register is empty, so the
    // input ready comes from a register alone.
    logic r_skid_valid;
    logic pipe_en;
    assign pipe_en    = !r_skid_valid;
    assign o_in_ready = pipe_en;

    // Generation pipeline.
    logic             stage_valid [NSTAGES+1];
    logic [CELLS-1:0] stage_ring  [NSTAGES+1];

    assign stage_valid[0] = i_in_valid;
    assign stage_ring[0]  = i_start_cells[CELLS-1:0];

    for (genvar s = 0; s < NSTAGES; s++) begin : g_stage
        localparam int K = s / GENS;
        t_stage_ctl ctl;

        assign ctl.en    = pipe_en;
        assign ctl.apply = (TOTAL_W'(K) < active_rules);
        assign ctl.rule  = r_rule_bytes[RULE_W*K +: RULE_W];

        ecac_gen_stage #(
            .CELLS (CELLS)
        ) u_gen (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl),
            .i_valid (stage_valid[s]),
            .i_ring  (stage_ring[s]),
            .o_valid (stage_valid[s+1]),
            .o_ring  (stage_ring[s+1])
        );
    end

    // Reduction of the final ring.
    logic             red_valid;
    logic             red_class;
    logic [CELLS-1:0] red_ring;

    ecac_reduce #(
        .CELLS (CELLS)
    ) u_reduce (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (pipe_en),
        .i_mode  (r_mode),
        .i_valid (stage_valid[NSTAGES]),
        .i_ring  (stage_ring[NSTAGES]),
        .o_valid (red_valid),
        .o_class (red_class),
        .o_ring  (red_ring)
    );

    // Output register with a skid register behind it. When the output is
    // held and a new beat arrives from the pipeline, that beat parks in the
    // skid register and the pipeline stops on the following cycle.
    logic             r_out_valid;
    logic             r_out_class;
    logic [CELLS-1:0] r_out_ring;
    logic             r_skid_class;
    logic [CELLS-1:0] r_skid_ring;
    logic             out_take;

    assign out_take = r_out_valid && i_out_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (out_take) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_valid <= red_valid;
        end else if (red_valid) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (out_take) begin
                r_out_class <= r_skid_class;
                r_out_ring  <= r_skid_ring;
            end
        end else if (!r_out_valid || out_take) begin
            r_out_class <= red_class;
            r_out_ring  <= red_ring;
        end else begin
            r_skid_class <= red_class;
            r_skid_ring  <= red_ring;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_class_bit   = r_out_class;
    assign o_final_cells = FIELD_W'(r_out_ring);

endmodule
